>>> design/max_flow_min_cut_assert.svh
// Assertion macros shared by the max flow / min cut modules.
`ifndef MAX_FLOW_MIN_CUT_ASSERT_SVH
`define MAX_FLOW_MIN_CUT_ASSERT_SVH

`ifndef SYNTHESIS
`define MFMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define MFMC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);
`else
`define MFMC_ASSERT(lbl, prop, msg)
`define MFMC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

>>> design/mfmc_pkg.sv
// Package: constants, types and state codes of the max flow / min cut block.
package mfmc_pkg;

    localparam int NODES      = 32;
    localparam int NODE_W     = 5;
    localparam int MAX_EDGES  = 256;
    localparam int ARC_SLOTS  = 2 * MAX_EDGES;
    localparam int ARC_W      = 9;
    localparam int LINK_W     = 10;
    localparam logic [LINK_W-1:0] NO_ARC = 10'd512;
    localparam int CAP_W      = 10;
    localparam int FLOW_W     = 18;
    localparam int ACC_W      = 19;
    localparam logic [FLOW_W-1:0] FLOW_MAX = 18'h3FFFF;
    localparam int LVL_W      = 5;
    localparam int DEPTH_W    = 6;
    localparam int ECNT_W     = 9;
    localparam int CNT_W      = 10;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_SINK   = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [CAP_W-1:0]  capacity;
        logic              last;
        logic              drop;
    } t_edge;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_F,
        S_LD_FL,
        S_LD_R,
        S_LD_RL,
        S_BFS_INIT,
        S_BFS_NODE,
        S_BFS_ARC,
        S_DFS_INIT,
        S_DFS_LOOK,
        S_DFS_EVAL,
        S_AUG_A,
        S_AUG_B,
        S_DONE
    } t_back_state;

endpackage

>>> design/max_flow_min_cut.sv
// Top level of the max flow / min cut block: register port, front end, back end.
//
// Usage:
//  Input channel (i_in_valid / o_in_stall) carries one directed edge per beat:
//  from_node, to_node, capacity and last. Edges go into a four-beat queue; the
//  back end takes each from the queue and stores a kept one as a forward and a reverse
//  arc. The beat with last set ends the graph and starts Dinic max flow
//  from the source register to the sink register. One result beat follows
//  on the output channel (o_out_valid / i_out_stall): max_flow, cut_set,
//  edges_dropped, bad_terminals. The flow run serializes every arc read
//  of BFS, DFS and augmentation through the arc memory's single read port.
//  A graph's edges beyond the 256th are dropped and flagged. Source equal
//  to sink gives zero flow with bad_terminals set.
//  Registers (APB, pready always high): source at 0x0, sink at 0x4.
//  Reset (synchronous, active low) empties the store and queue; source is 0,
//  sink is 1. While the receiver stalls, the result holds and edges still
//  queue; the back end waits for the output register before clearing.
module max_flow_min_cut import mfmc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [NODE_W-1:0] i_from_node,
    input  logic [NODE_W-1:0] i_to_node,
    input  logic [CAP_W-1:0]  i_capacity,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [FLOW_W-1:0] o_max_flow,
    output logic [NODES-1:0]  o_cut_set,
    output logic              o_edges_dropped,
    output logic              o_bad_terminals
);
    logic [NODE_W-1:0] r_source;
    logic [NODE_W-1:0] r_sink;
    logic              w_wr;
    logic              w_q_valid;
    logic              w_q_pop;
    t_edge             w_q_edge;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source <= NODE_W'(0);
            r_sink   <= NODE_W'(1);
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_SOURCE: r_source <= pwdata[NODE_W-1:0];
                REG_SINK:   r_sink   <= pwdata[NODE_W-1:0];
                default:    r_sink   <= r_sink;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SOURCE: prdata = DATA_W'(r_source);
            REG_SINK:   prdata = DATA_W'(r_sink);
            default:    prdata = '0;
        endcase
    end

    mfmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_from_node (i_from_node),
        .i_to_node   (i_to_node),
        .i_capacity  (i_capacity),
        .i_last      (i_last),
        .o_q_valid   (w_q_valid),
        .o_q_edge    (w_q_edge),
        .i_q_pop     (w_q_pop)
    );

    mfmc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_source        (r_source),
        .i_sink          (r_sink),
        .i_q_valid       (w_q_valid),
        .i_q_edge        (w_q_edge),
        .o_q_pop         (w_q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_max_flow      (o_max_flow),
        .o_cut_set       (o_cut_set),
        .o_edges_dropped (o_edges_dropped),
        .o_bad_terminals (o_bad_terminals)
    );
endmodule

>>> design/mfmc_ram.sv
// Generic single write port RAM with registered read.
module mfmc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/mfmc_front.sv
// Front end: accepts edge beats, tags edges past the store limit, queues them.
`include "max_flow_min_cut_assert.svh"
module mfmc_front import mfmc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [NODE_W-1:0] i_from_node,
    input  logic [NODE_W-1:0] i_to_node,
    input  logic [CAP_W-1:0]  i_capacity,
    input  logic              i_last,
    output logic              o_q_valid,
    output t_edge             o_q_edge,
    input  logic              i_q_pop
);
    t_edge               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp;
    logic [FIFO_AW-1:0]  r_rp;
    logic [FIFO_CW-1:0]  r_cnt;
    logic [ECNT_W-1:0]   r_ecnt;
    logic                w_push;
    logic                w_pop;
    logic                w_drop;
    t_edge               w_edge;

    assign o_in_stall = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_q_pop && (r_cnt != '0);
    assign w_drop     = (r_ecnt == ECNT_W'(MAX_EDGES));

    always_comb begin
        w_edge.from_node = i_from_node;
        w_edge.to_node   = i_to_node;
        w_edge.capacity  = i_capacity;
        w_edge.last      = i_last;
        w_edge.drop      = w_drop;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_ecnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
                if (i_last) begin
                    r_ecnt <= '0;
                end else if (!w_drop) begin
                    r_ecnt <= r_ecnt + 1'b1;
                end
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + FIFO_CW'(w_push) - FIFO_CW'(w_pop);
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_edge  = r_mem[r_rp];

    `MFMC_ASSERT(a_fifo_bound, r_cnt <= FIFO_CW'(FIFO_DEPTH), "queue count beyond depth")
    `MFMC_ASSERT(a_ecnt_bound, r_ecnt <= ECNT_W'(MAX_EDGES), "edge count beyond store")
    `MFMC_ASSERT(a_pop_nonempty, !i_q_pop || (r_cnt != '0), "pop from empty queue")
endmodule

>>> design/mfmc_back.sv
// Back end: arc store, level BFS, blocking-flow DFS and result register.
`include "max_flow_min_cut_assert.svh"
module mfmc_back import mfmc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NODE_W-1:0] i_source,
    input  logic [NODE_W-1:0] i_sink,
    input  logic              i_q_valid,
    input  t_edge             i_q_edge,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [FLOW_W-1:0] o_max_flow,
    output logic [NODES-1:0]  o_cut_set,
    output logic              o_edges_dropped,
    output logic              o_bad_terminals
);
    t_back_state r_state, n_state;
    t_edge       r_edge, n_edge;
    logic [CNT_W-1:0]   r_arc_cnt, n_arc_cnt;
    logic               r_ovf, n_ovf;
    logic               r_bad, n_bad;
    logic [LINK_W-1:0]  r_first [NODES];
    logic [LINK_W-1:0]  n_first [NODES];
    logic [LINK_W-1:0]  r_tail [NODES];
    logic [LINK_W-1:0]  n_tail [NODES];
    logic [LINK_W-1:0]  r_cur [NODES];
    logic [LINK_W-1:0]  n_cur [NODES];
    logic [LVL_W-1:0]   r_level [NODES];
    logic [LVL_W-1:0]   n_level [NODES];
    logic [NODES-1:0]   r_reached, n_reached;
    logic [NODE_W-1:0]  r_queue [NODES];
    logic [NODE_W-1:0]  n_queue [NODES];
    logic [DEPTH_W-1:0] r_head, n_head;
    logic [DEPTH_W-1:0] r_qtail, n_qtail;
    logic [NODE_W-1:0]  r_u, n_u;
    logic [LVL_W-1:0]   r_ulvl, n_ulvl;
    logic [ARC_W-1:0]   r_a, n_a;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [ARC_W-1:0]   r_stk_arc [NODES];
    logic [ARC_W-1:0]   n_stk_arc [NODES];
    logic [NODE_W-1:0]  r_stk_from [NODES];
    logic [NODE_W-1:0]  n_stk_from [NODES];
    logic [LINK_W-1:0]  r_stk_next [NODES];
    logic [LINK_W-1:0]  n_stk_next [NODES];
    logic [CAP_W-1:0]   r_stk_res [NODES];
    logic [CAP_W-1:0]   n_stk_res [NODES];
    logic [CAP_W-1:0]   r_stk_min [NODES];
    logic [CAP_W-1:0]   n_stk_min [NODES];
    logic [CAP_W-1:0]   r_sent, n_sent;
    logic [ACC_W-1:0]   r_flow, n_flow;

    logic               r_ovalid;
    logic [FLOW_W-1:0]  r_oflow;
    logic [NODES-1:0]   r_ocut;
    logic               r_odrop;
    logic               r_obad;
    logic               w_oready;
    logic               w_oload;

    logic               w_tgt_we, w_res_we, w_nxt_we;
    logic [ARC_W-1:0]   w_tgt_wa, w_res_wa, w_nxt_wa;
    logic [NODE_W-1:0]  w_tgt_wd;
    logic [CAP_W-1:0]   w_res_wd;
    logic [LINK_W-1:0]  w_nxt_wd;
    logic [ARC_W-1:0]   w_raddr;
    logic [NODE_W-1:0]  w_tgt_rd;
    logic [CAP_W-1:0]   w_res_rd;
    logic [LINK_W-1:0]  w_nxt_rd;

    logic [ARC_W-1:0]   w_fwd;
    logic [ARC_W-1:0]   w_rev;
    logic [NODE_W-1:0]  w_top;
    logic [NODE_W-1:0]  w_hd;
    logic [NODE_W-1:0]  w_v;
    logic               w_ok;
    logic [CAP_W-1:0]   w_min;
    logic [LINK_W-1:0]  w_a;

    mfmc_ram #(.W(NODE_W), .D(ARC_SLOTS)) u_tgt (
        .i_clk(i_clk), .i_we(w_tgt_we), .i_waddr(w_tgt_wa), .i_wdata(w_tgt_wd),
        .i_raddr(w_raddr), .o_rdata(w_tgt_rd));
    mfmc_ram #(.W(CAP_W), .D(ARC_SLOTS)) u_res (
        .i_clk(i_clk), .i_we(w_res_we), .i_waddr(w_res_wa), .i_wdata(w_res_wd),
        .i_raddr(w_raddr), .o_rdata(w_res_rd));
    mfmc_ram #(.W(LINK_W), .D(ARC_SLOTS)) u_nxt (
        .i_clk(i_clk), .i_we(w_nxt_we), .i_waddr(w_nxt_wa), .i_wdata(w_nxt_wd),
        .i_raddr(w_raddr), .o_rdata(w_nxt_rd));

    assign w_oready = !r_ovalid || !i_out_stall;
    assign w_fwd    = r_arc_cnt[ARC_W-1:0];
    assign w_rev    = {w_fwd[ARC_W-1:1], 1'b1};
    assign w_top    = NODE_W'(r_depth - 1'b1);
    assign w_hd     = r_head[NODE_W-1:0];
    assign w_v      = w_tgt_rd;
    assign w_a      = r_cur[r_u];
    assign w_ok     = (w_res_rd != '0) && r_reached[w_v] && (r_level[r_u] != '1)
                      && (r_level[w_v] == r_level[r_u] + 1'b1);
    assign w_min    = (r_depth == '0 || w_res_rd < r_stk_min[w_top])
                      ? w_res_rd : r_stk_min[w_top];

    always_comb begin
        n_state   = r_state;
        n_edge    = r_edge;
        n_arc_cnt = r_arc_cnt;
        n_ovf     = r_ovf;
        n_bad     = r_bad;
        n_first   = r_first;
        n_tail    = r_tail;
        n_cur     = r_cur;
        n_level   = r_level;
        n_reached = r_reached;
        n_queue   = r_queue;
        n_head    = r_head;
        n_qtail   = r_qtail;
        n_u       = r_u;
        n_ulvl    = r_ulvl;
        n_a       = r_a;
        n_depth   = r_depth;
        n_stk_arc  = r_stk_arc;
        n_stk_from = r_stk_from;
        n_stk_next = r_stk_next;
        n_stk_res  = r_stk_res;
        n_stk_min  = r_stk_min;
        n_sent    = r_sent;
        n_flow    = r_flow;
        o_q_pop   = 1'b0;
        w_oload   = 1'b0;
        w_tgt_we  = 1'b0;
        w_res_we  = 1'b0;
        w_nxt_we  = 1'b0;
        w_tgt_wa  = w_fwd;
        w_res_wa  = w_fwd;
        w_nxt_wa  = w_fwd;
        w_tgt_wd  = r_edge.to_node;
        w_res_wd  = r_edge.capacity;
        w_nxt_wd  = NO_ARC;
        w_raddr   = r_a;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_edge  = i_q_edge;
                    if (i_q_edge.drop) begin
                        n_ovf = 1'b1;
                        if (i_q_edge.last) begin
                            n_bad   = (i_source == i_sink);
                            n_state = (i_source == i_sink) ? S_DONE : S_BFS_INIT;
                        end
                    end else begin
                        n_state = S_LD_F;
                    end
                end
            end
            S_LD_F: begin
                w_tgt_we = 1'b1;
                w_res_we = 1'b1;
                w_nxt_we = 1'b1;
                n_state  = S_LD_FL;
            end
            S_LD_FL: begin
                if (r_first[r_edge.from_node] == NO_ARC) begin
                    n_first[r_edge.from_node] = LINK_W'(w_fwd);
                end else begin
                    w_nxt_we = 1'b1;
                    w_nxt_wa = r_tail[r_edge.from_node][ARC_W-1:0];
                    w_nxt_wd = LINK_W'(w_fwd);
                end
                n_tail[r_edge.from_node] = LINK_W'(w_fwd);
                n_state = S_LD_R;
            end
            S_LD_R: begin
                w_tgt_we = 1'b1;
                w_res_we = 1'b1;
                w_nxt_we = 1'b1;
                w_tgt_wa = w_rev;
                w_res_wa = w_rev;
                w_nxt_wa = w_rev;
                w_tgt_wd = r_edge.from_node;
                w_res_wd = '0;
                n_state  = S_LD_RL;
            end
            S_LD_RL: begin
                if (r_first[r_edge.to_node] == NO_ARC) begin
                    n_first[r_edge.to_node] = LINK_W'(w_rev);
                end else begin
                    w_nxt_we = 1'b1;
                    w_nxt_wa = r_tail[r_edge.to_node][ARC_W-1:0];
                    w_nxt_wd = LINK_W'(w_rev);
                end
                n_tail[r_edge.to_node] = LINK_W'(w_rev);
                n_arc_cnt = r_arc_cnt + CNT_W'(2);
                if (r_edge.last) begin
                    n_bad   = (i_source == i_sink);
                    n_state = (i_source == i_sink) ? S_DONE : S_BFS_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BFS_INIT: begin
                n_reached = '0;
                n_reached[i_source] = 1'b1;
                n_level[i_source]   = '0;
                n_queue[0] = i_source;
                n_head     = '0;
                n_qtail    = DEPTH_W'(1);
                n_state    = S_BFS_NODE;
            end
            S_BFS_NODE: begin
                if (r_head < r_qtail) begin
                    n_head = r_head + 1'b1;
                    n_u    = r_queue[w_hd];
                    n_ulvl = r_level[r_queue[w_hd]];
                    if (r_first[r_queue[w_hd]] != NO_ARC) begin
                        w_raddr = r_first[r_queue[w_hd]][ARC_W-1:0];
                        n_state = S_BFS_ARC;
                    end
                end else if (r_reached[i_sink]) begin
                    n_state = S_DFS_INIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BFS_ARC: begin
                if (w_res_rd != '0 && !r_reached[w_v]) begin
                    n_level[w_v]   = r_ulvl + 1'b1;
                    n_reached[w_v] = 1'b1;
                    if (r_qtail < DEPTH_W'(NODES)) begin
                        n_queue[r_qtail[NODE_W-1:0]] = w_v;
                        n_qtail = r_qtail + 1'b1;
                    end
                end
                if (w_nxt_rd == NO_ARC) begin
                    n_state = S_BFS_NODE;
                end else begin
                    w_raddr = w_nxt_rd[ARC_W-1:0];
                end
            end
            S_DFS_INIT: begin
                n_cur   = r_first;
                n_depth = '0;
                n_u     = i_source;
                n_state = S_DFS_LOOK;
            end
            S_DFS_LOOK: begin
                if (w_a == NO_ARC) begin
                    if (r_depth == '0) begin
                        n_state = S_BFS_INIT;
                    end else begin
                        n_u     = r_stk_from[w_top];
                        n_cur[r_stk_from[w_top]] = r_stk_next[w_top];
                        n_depth = r_depth - 1'b1;
                    end
                end else begin
                    w_raddr = w_a[ARC_W-1:0];
                    n_a     = w_a[ARC_W-1:0];
                    n_state = S_DFS_EVAL;
                end
            end
            S_DFS_EVAL: begin
                if (w_ok) begin
                    n_stk_arc[r_depth[NODE_W-1:0]]  = r_a;
                    n_stk_from[r_depth[NODE_W-1:0]] = r_u;
                    n_stk_next[r_depth[NODE_W-1:0]] = w_nxt_rd;
                    n_stk_res[r_depth[NODE_W-1:0]]  = w_res_rd;
                    n_stk_min[r_depth[NODE_W-1:0]]  = w_min;
                    n_depth = r_depth + 1'b1;
                    if (w_v == i_sink) begin
                        n_sent  = w_min;
                        n_state = S_AUG_A;
                    end else begin
                        n_u     = w_v;
                        n_state = S_DFS_LOOK;
                    end
                end else begin
                    n_cur[r_u] = w_nxt_rd;
                    n_state    = S_DFS_LOOK;
                end
            end
            S_AUG_A: begin
                w_res_we = 1'b1;
                w_res_wa = r_stk_arc[w_top];
                w_res_wd = r_stk_res[w_top] - r_sent;
                w_raddr  = r_stk_arc[w_top] ^ ARC_W'(1);
                n_state  = S_AUG_B;
            end
            S_AUG_B: begin
                w_res_we = 1'b1;
                w_res_wa = r_stk_arc[w_top] ^ ARC_W'(1);
                w_res_wd = w_res_rd + r_sent;
                n_depth  = r_depth - 1'b1;
                if (r_depth == DEPTH_W'(1)) begin
                    n_flow  = r_flow + ACC_W'(r_sent);
                    n_u     = i_source;
                    n_state = S_DFS_LOOK;
                end else begin
                    n_state = S_AUG_A;
                end
            end
            S_DONE: begin
                if (w_oready) begin
                    w_oload   = 1'b1;
                    n_arc_cnt = '0;
                    n_ovf     = 1'b0;
                    n_bad     = 1'b0;
                    n_flow    = '0;
                    n_reached = '0;
                    for (int i = 0; i < NODES; i++) begin
                        n_first[i] = NO_ARC;
                        n_tail[i]  = NO_ARC;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_arc_cnt <= '0;
            r_ovf     <= 1'b0;
            r_bad     <= 1'b0;
            r_reached <= '0;
            r_flow    <= '0;
            r_depth   <= '0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < NODES; i++) begin
                r_first[i] <= NO_ARC;
                r_tail[i]  <= NO_ARC;
            end
        end else begin
            r_state   <= n_state;
            r_arc_cnt <= n_arc_cnt;
            r_ovf     <= n_ovf;
            r_bad     <= n_bad;
            r_reached <= n_reached;
            r_flow    <= n_flow;
            r_depth   <= n_depth;
            r_first   <= n_first;
            r_tail    <= n_tail;
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge     <= n_edge;
        r_cur      <= n_cur;
        r_level    <= n_level;
        r_queue    <= n_queue;
        r_head     <= n_head;
        r_qtail    <= n_qtail;
        r_u        <= n_u;
        r_ulvl     <= n_ulvl;
        r_a        <= n_a;
        r_stk_arc  <= n_stk_arc;
        r_stk_from <= n_stk_from;
        r_stk_next <= n_stk_next;
        r_stk_res  <= n_stk_res;
        r_stk_min  <= n_stk_min;
        r_sent     <= n_sent;
        if (w_oload) begin
            r_oflow <= (r_flow > ACC_W'(FLOW_MAX)) ? FLOW_MAX : r_flow[FLOW_W-1:0];
            r_ocut  <= r_bad ? '0 : r_reached;
            r_odrop <= r_ovf;
            r_obad  <= r_bad;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_max_flow      = r_oflow;
    assign o_cut_set       = r_ocut;
    assign o_edges_dropped = r_odrop;
    assign o_bad_terminals = r_obad;

    `MFMC_ASSERT(a_depth_bound, r_depth <= DEPTH_W'(NODES), "DFS path deeper than node count")
    `MFMC_ASSERT(a_bad_zero, !(r_ovalid && r_obad) || (r_oflow == '0 && r_ocut == '0),
        "bad terminals with nonzero result")
    `MFMC_ASSERT_NEXT(a_clear, r_state == S_DONE && w_oready,
        r_arc_cnt == '0 && r_state == S_IDLE && r_ovalid, "store not cleared after result")
    `MFMC_ASSERT(a_arc_bound, r_arc_cnt <= CNT_W'(ARC_SLOTS), "arc count beyond store")
endmodule

>>> sim/max_flow_min_cut_tb.sv
// Testbench for max_flow_min_cut: loads random and directed graphs, checks each flow result.
`timescale 1ns / 100ps

module max_flow_min_cut_tb import mfmc_pkg::*; ();

    localparam int PUSH_LIMIT = 1000000;
    localparam int SETTLE     = 300;

    typedef struct {
        logic [FLOW_W-1:0] max_flow;
        logic [NODES-1:0]  cut_set;
        logic              edges_dropped;
        logic              bad_terminals;
    } t_flow_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [NODE_W-1:0] i_from_node;
    logic [NODE_W-1:0] i_to_node;
    logic [CAP_W-1:0]  i_capacity;
    logic              i_last;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [FLOW_W-1:0] o_max_flow;
    logic [NODES-1:0]  o_cut_set;
    logic              o_edges_dropped;
    logic              o_bad_terminals;

    max_flow_min_cut u_dut (.*);

    // graph model state
    int          mdl_src, mdl_snk;
    int          arc_to[ARC_SLOTS];
    int          arc_mate[ARC_SLOTS];
    int          arc_res[ARC_SLOTS];
    int          arc_link[ARC_SLOTS];
    int          head_arc[NODES];
    int          tail_arc[NODES];
    int          level[NODES];
    int          cur_arc[NODES];
    logic [NODES-1:0] reached;
    int          n_arcs;
    logic        dropped_seen;

    t_flow_result flow_q[$];
    int          n_errors;
    int          n_edges;
    int          n_results;
    int          n_graphs;
    bit          out_calm;

    always #5 i_clk = ~i_clk;

    function automatic void clear_graph();
        for (int i = 0; i < NODES; i++) begin
            head_arc[i] = ARC_SLOTS;
            tail_arc[i] = ARC_SLOTS;
            level[i]    = 0;
            cur_arc[i]  = 0;
        end
        reached      = '0;
        n_arcs       = 0;
        dropped_seen = 1'b0;
    endfunction

    function automatic void link_arc(int idx, int owner, int dst, int cap);
        arc_to[idx]   = dst;
        arc_res[idx]  = cap;
        arc_link[idx] = ARC_SLOTS;
        if (head_arc[owner] == ARC_SLOTS)
            head_arc[owner] = idx;
        else
            arc_link[tail_arc[owner]] = idx;
        tail_arc[owner] = idx;
    endfunction

    function automatic bit level_graph(int s, int t);
        int q[NODES];
        int qh, qt, u, a, v;
        qh = 0;
        qt = 0;
        reached = '0;
        reached[s] = 1'b1;
        level[s] = 0;
        q[qt] = s;
        qt++;
        while (qh < qt) begin
            u = q[qh];
            qh++;
            a = head_arc[u];
            while (a < ARC_SLOTS) begin
                v = arc_to[a];
                if (arc_res[a] != 0 && !reached[v]) begin
                    level[v] = level[u] + 1;
                    reached[v] = 1'b1;
                    if (qt < NODES) begin
                        q[qt] = v;
                        qt++;
                    end
                end
                a = arc_link[a];
            end
        end
        return reached[t];
    endfunction

    function automatic int push_flow(int u, int t, int lim);
        int a, v, sub, sent;
        if (u == t)
            return lim;
        a = cur_arc[u];
        while (a < ARC_SLOTS) begin
            v = arc_to[a];
            if (arc_res[a] != 0 && reached[v] && level[v] == level[u] + 1) begin
                sub = (lim < arc_res[a]) ? lim : arc_res[a];
                sent = push_flow(v, t, sub);
                if (sent != 0) begin
                    arc_res[a] -= sent;
                    arc_res[arc_mate[a]] += sent;
                    cur_arc[u] = a;
                    return sent;
                end
            end
            a = arc_link[a];
            cur_arc[u] = a;
        end
        return 0;
    endfunction

    function automatic void add_edge(int u, int v, int cap, bit last);
        t_flow_result r;
        int flow, f;
        if (n_arcs + 2 > ARC_SLOTS) begin
            dropped_seen = 1'b1;
        end else begin
            arc_mate[n_arcs]     = n_arcs + 1;
            arc_mate[n_arcs + 1] = n_arcs;
            link_arc(n_arcs, u, v, cap);
            link_arc(n_arcs + 1, v, u, 0);
            n_arcs += 2;
        end
        if (!last)
            return;
        flow = 0;
        r.cut_set = '0;
        r.bad_terminals = (mdl_src == mdl_snk);
        if (!r.bad_terminals) begin
            while (level_graph(mdl_src, mdl_snk)) begin
                for (int i = 0; i < NODES; i++)
                    cur_arc[i] = head_arc[i];
                f = push_flow(mdl_src, mdl_snk, PUSH_LIMIT);
                while (f != 0) begin
                    flow += f;
                    f = push_flow(mdl_src, mdl_snk, PUSH_LIMIT);
                end
            end
            r.cut_set = reached;
        end
        r.max_flow = (flow > FLOW_MAX) ? FLOW_MAX : FLOW_W'(flow);
        r.edges_dropped = dropped_seen;
        flow_q.insert(flow_q.size(), r);
        clear_graph();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stall with calm stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0)
            out_calm <= ~out_calm;
        if (out_calm)
            i_out_stall <= 1'b0;
        else if (i_out_stall)
            i_out_stall <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 29) == 0);
        else
            i_out_stall <= ($urandom_range(0, 9) < 3);
    end

    // beat is taken at the next rising edge; payload is stable here
    always @(negedge i_clk) begin
        t_flow_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (flow_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
            end else begin
                e = flow_q.pop_front();
                if (o_max_flow !== e.max_flow) begin
                    $error("max_flow expected %0d actual %0d", e.max_flow, o_max_flow);
                    n_errors++;
                end
                if (o_cut_set !== e.cut_set) begin
                    $error("cut_set expected %h actual %h", e.cut_set, o_cut_set);
                    n_errors++;
                end
                if (o_edges_dropped !== e.edges_dropped) begin
                    $error("edges_dropped expected %0b actual %0b",
                           e.edges_dropped, o_edges_dropped);
                    n_errors++;
                end
                if (o_bad_terminals !== e.bad_terminals) begin
                    $error("bad_terminals expected %0b actual %0b",
                           e.bad_terminals, o_bad_terminals);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_edge(int u, int v, int cap, bit last, bit gaps = 1'b1);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_from_node <= NODE_W'(u);
        i_to_node   <= NODE_W'(v);
        i_capacity  <= CAP_W'(cap);
        i_last      <= last;
        @(negedge i_clk);
        while (o_in_stall) @(negedge i_clk);
        @(posedge i_clk);
        add_edge(u, v, cap, last);
        n_edges++;
        if (last) n_graphs++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (flow_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SOURCE) mdl_src = value;
        else mdl_snk = value;
        @(posedge i_clk);
    endtask

    task automatic set_terminals(int s, int t);
        drain();
        write_reg(REG_SOURCE, s);
        write_reg(REG_SINK, t);
    endtask

    task automatic test_basic_graphs();
        // reset terminals 0 -> 1
        send_edge(0, 1, 1023, 1'b1);
        send_edge(7, 9, 5, 1'b1);
        send_edge(0, 2, 10, 1'b0);
        send_edge(2, 1, 4, 1'b0);
        send_edge(0, 1, 0, 1'b0);
        send_edge(2, 2, 1023, 1'b0);
        send_edge(0, 3, 6, 1'b0);
        send_edge(3, 2, 6, 1'b0);
        send_edge(2, 1, 7, 1'b1);
    endtask

    task automatic test_terminal_extremes();
        set_terminals(31, 0);
        send_edge(31, 16, 1023, 1'b0);
        send_edge(16, 0, 1023, 1'b0);
        send_edge(31, 0, 1, 1'b1);
        set_terminals(0, 31);
        send_edge(0, 31, 1023, 1'b0);
        send_edge(0, 31, 1023, 1'b0);
        send_edge(31, 0, 1023, 1'b1);
        set_terminals(21, 21);
        send_edge(21, 10, 300, 1'b0);
        send_edge(10, 21, 300, 1'b1);
        set_terminals(10, 21);
        send_edge(10, 21, 0, 1'b1);
    endtask

    task automatic test_store_overflow();
        for (int i = 0; i < MAX_EDGES + 4; i++)
            send_edge($urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 1023), i == MAX_EDGES + 3, 1'b0);
        send_edge(10, 21, 9, 1'b1);
    endtask

    task automatic test_random_graphs();
        int pool[6];
        int n, r, u, v, cap, lim;
        while (n_edges < 1800) begin
            if ($urandom_range(0, 11) == 0) begin
                u = $urandom_range(0, 31);
                v = ($urandom_range(0, 19) == 0) ? u : $urandom_range(0, 31);
                set_terminals(u, v);
            end else if ($urandom_range(0, 15) == 0) begin
                drain();
            end
            for (int i = 0; i < 6; i++) pool[i] = $urandom_range(0, 31);
            r = $urandom_range(0, 99);
            n = (r < 80) ? $urandom_range(1, 10) :
                (r < 95) ? $urandom_range(11, 40) : $urandom_range(41, 120);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 9);
                u = (r < 3) ? mdl_src : (r < 4) ? mdl_snk :
                    (r < 9) ? pool[$urandom_range(0, 5)] : $urandom_range(0, 31);
                r = $urandom_range(0, 9);
                v = (r < 3) ? mdl_snk : (r < 4) ? mdl_src :
                    (r < 9) ? pool[$urandom_range(0, 5)] : $urandom_range(0, 31);
                r = $urandom_range(0, 9);
                lim = ($urandom_range(0, 1) == 0) ? 15 : 1023;
                cap = (r == 0) ? 0 : (r == 1) ? 1023 : $urandom_range(1, lim);
                send_edge(u, v, cap, i == n - 1);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_from_node = '0;
        i_to_node = '0;
        i_capacity = '0;
        i_last = 1'b0;
        i_out_stall = 1'b0;
        out_calm = 1'b0;
        n_errors = 0;
        n_edges = 0;
        n_results = 0;
        n_graphs = 0;
        mdl_src = 0;
        mdl_snk = 1;
        clear_graph();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_graphs();
        test_terminal_extremes();
        test_store_overflow();
        set_terminals(0, 1);
        test_random_graphs();
        drain();

        $display("Covered %0d edge beats in %0d graphs, %0d flow results checked,",
                 n_edges, n_graphs, n_results);
        $display("including store overflow, equal terminals and terminal extremes.");
        if (n_errors == 0 && flow_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
